[sv/l2_mesi_directory_line_controller_macros.svh]
// Assertion macros for the line controller
`ifndef L2_MESI_DIRECTORY_LINE_CONTROLLER_MACROS_SVH
`define L2_MESI_DIRECTORY_LINE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define L2D_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define L2D_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define L2D_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define L2D_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

[sv/l2d_pkg.sv]
package l2d_pkg;
  localparam int DATA_BITS_DEF = 64;
  localparam int TAG_BITS_DEF = 26;
  localparam int SOURCE_BITS_DEF = 6;
  localparam int SHARER_COUNT_DEF = 64;
  localparam int TYPE_BITS = 8;

  localparam logic [7:0] T_STORE = 8'd2;
  localparam logic [7:0] T_WB = 8'd12;
  localparam logic [7:0] T_LOAD = 8'd31;
  localparam logic [7:0] T_FWD_LOAD = 8'd16;
  localparam logic [7:0] T_FWD_STORE = 8'd17;
  localparam logic [7:0] T_FWD_INV = 8'd18;
  localparam logic [7:0] T_MEM_LOAD = 8'd19;
  localparam logic [7:0] T_MEM_STORE = 8'd20;
  localparam logic [7:0] T_ACK_LFWD = 8'd21;
  localparam logic [7:0] T_ACK_SFWD = 8'd22;
  localparam logic [7:0] T_ACK_INV = 8'd23;
  localparam logic [7:0] T_ACK_LMEM = 8'd24;
  localparam logic [7:0] T_ACK_SMEM = 8'd25;
  localparam logic [7:0] T_NODATA = 8'd28;
  localparam logic [7:0] T_DATA = 8'd29;

  localparam logic [1:0] K_REQ = 2'd0;
  localparam logic [1:0] K_RSP = 2'd1;
  localparam logic [1:0] K_RPL = 2'd2;

  localparam logic [1:0] VD_INVAL = 2'd0;
  localparam logic [1:0] VD_CLEAN = 2'd2;
  localparam logic [1:0] VD_DIRTY = 2'd3;
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;
  localparam logic [1:0] PH_FREE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_PEND = 2'd2;

  // classified operation passed from front to back
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_REQ = 3'd1;
  localparam logic [2:0] OP_RPL = 3'd2;
  localparam logic [2:0] OP_WB = 3'd3;
  localparam logic [2:0] OP_FWDACK = 3'd4;
  localparam logic [2:0] OP_INVACK = 3'd5;
  localparam logic [2:0] OP_LMEM = 3'd6;
  localparam logic [2:0] OP_SMEM = 3'd7;
endpackage

[sv/l2_mesi_directory_line_controller.sv]
// An accepted input is written into the classify queue; the line update then registers the result.
// One item per cycle while the result side does not stall; the line registers update once per item.
// A two-entry queue parts front and back; the result register parts back from the sink.
// Reset: synchronous active-low rst_n clears line, slot and queue pointer state to zero.
`include "l2_mesi_directory_line_controller_macros.svh"
module l2_mesi_directory_line_controller #(
  parameter int DATA_BITS = l2d_pkg::DATA_BITS_DEF,
  parameter int TAG_BITS = l2d_pkg::TAG_BITS_DEF,
  parameter int SOURCE_BITS = l2d_pkg::SOURCE_BITS_DEF,
  parameter int SHARER_COUNT = l2d_pkg::SHARER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_msg_type,
  input  logic [DATA_BITS-1:0] in_msg_data,
  input  logic [SOURCE_BITS-1:0] in_msg_source,
  input  logic [TAG_BITS-1:0] in_msg_tag,
  output logic out_valid,
  input  logic out_ready,
  output logic out_accepted,
  output logic out_sent,
  output logic [7:0] out_type,
  output logic [1:0] out_mesi,
  output logic [DATA_BITS-1:0] out_data,
  output logic [TAG_BITS-1:0] out_tag
);
  logic q_valid, q_ready, q_lfwd, q_store;
  logic [2:0] q_op;
  logic [DATA_BITS-1:0] q_data;
  logic [SOURCE_BITS-1:0] q_src;
  logic [TAG_BITS-1:0] q_tag;
  logic [1:0] slot_phase;

  l2d_front #(.DATA_BITS(DATA_BITS), .TAG_BITS(TAG_BITS), .SOURCE_BITS(SOURCE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_msg_type, .in_msg_data,
    .in_msg_source, .in_msg_tag, .q_valid, .q_ready, .q_op, .q_lfwd, .q_store,
    .q_data, .q_src, .q_tag
  );

  l2d_back #(.DATA_BITS(DATA_BITS), .TAG_BITS(TAG_BITS), .SOURCE_BITS(SOURCE_BITS),
             .SHARER_COUNT(SHARER_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_op, .q_lfwd, .q_store, .q_data, .q_src,
    .q_tag, .out_valid, .out_ready, .out_accepted, .out_sent, .out_type, .out_mesi,
    .out_data, .out_tag, .slot_phase
  );

  `L2D_ASSERT_IMPL(a_sent_acc, clk, rst_n, out_valid && out_sent |-> out_accepted, "sent without accept")
  `L2D_ASSERT_IMPL(a_phase, clk, rst_n, slot_phase != 2'd3, "bad slot phase")
  `L2D_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_type), "result dropped")
endmodule

[sv/l2d_front.sv]
module l2d_front #(
  parameter int DATA_BITS = l2d_pkg::DATA_BITS_DEF,
  parameter int TAG_BITS = l2d_pkg::TAG_BITS_DEF,
  parameter int SOURCE_BITS = l2d_pkg::SOURCE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_msg_type,
  input  logic [DATA_BITS-1:0] in_msg_data,
  input  logic [SOURCE_BITS-1:0] in_msg_source,
  input  logic [TAG_BITS-1:0] in_msg_tag,
  output logic q_valid,
  input  logic q_ready,
  output logic [2:0] q_op,
  output logic q_lfwd,
  output logic q_store,
  output logic [DATA_BITS-1:0] q_data,
  output logic [SOURCE_BITS-1:0] q_src,
  output logic [TAG_BITS-1:0] q_tag
);
  localparam int W = 3 + 1 + 1 + DATA_BITS + SOURCE_BITS + TAG_BITS;
  logic [W-1:0] ent_r [2];
  logic [W-1:0] ent_nxt;
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [2:0] op;
  logic push, pop;

  always_comb begin
    op = l2d_pkg::OP_NONE;
    case (in_kind)
      l2d_pkg::K_REQ:
        if (in_msg_type == l2d_pkg::T_LOAD || in_msg_type == l2d_pkg::T_STORE) begin
          op = l2d_pkg::OP_REQ;
        end
      l2d_pkg::K_RPL: op = l2d_pkg::OP_RPL;
      l2d_pkg::K_RSP:
        case (in_msg_type)
          l2d_pkg::T_WB: op = l2d_pkg::OP_WB;
          l2d_pkg::T_ACK_LFWD, l2d_pkg::T_ACK_SFWD: op = l2d_pkg::OP_FWDACK;
          l2d_pkg::T_ACK_INV: op = l2d_pkg::OP_INVACK;
          l2d_pkg::T_ACK_LMEM: op = l2d_pkg::OP_LMEM;
          l2d_pkg::T_ACK_SMEM: op = l2d_pkg::OP_SMEM;
          default: op = l2d_pkg::OP_NONE;
        endcase
      default: op = l2d_pkg::OP_NONE;
    endcase
    ent_nxt = {op, in_msg_type == l2d_pkg::T_ACK_LFWD, in_msg_type == l2d_pkg::T_STORE,
               in_msg_data, in_msg_source, in_msg_tag};
  end

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign pop = q_valid && q_ready;
  assign {q_op, q_lfwd, q_store, q_data, q_src, q_tag} = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= ent_nxt;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[sv/l2d_back.sv]
module l2d_back #(
  parameter int DATA_BITS = l2d_pkg::DATA_BITS_DEF,
  parameter int TAG_BITS = l2d_pkg::TAG_BITS_DEF,
  parameter int SOURCE_BITS = l2d_pkg::SOURCE_BITS_DEF,
  parameter int SHARER_COUNT = l2d_pkg::SHARER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  logic [2:0] q_op,
  input  logic q_lfwd,
  input  logic q_store,
  input  logic [DATA_BITS-1:0] q_data,
  input  logic [SOURCE_BITS-1:0] q_src,
  input  logic [TAG_BITS-1:0] q_tag,
  output logic out_valid,
  input  logic out_ready,
  output logic out_accepted,
  output logic out_sent,
  output logic [7:0] out_type,
  output logic [1:0] out_mesi,
  output logic [DATA_BITS-1:0] out_data,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [1:0] slot_phase
);
  logic [1:0] vd_r, vd_nxt, mesi_r, mesi_nxt, ph_r, ph_nxt;
  logic [TAG_BITS-1:0] ltag_r, ltag_nxt, stag_r, stag_nxt;
  logic [DATA_BITS-1:0] ldata_r, ldata_nxt, sdata_r, sdata_nxt;
  logic [SOURCE_BITS-1:0] own_r, own_nxt, ssrc_r, ssrc_nxt;
  logic [SHARER_COUNT-1:0] shr_r, shr_nxt, sbit;
  logic [7:0] stype_r, stype_nxt;
  logic ov_r, acc_r, sent_r;
  logic [7:0] ty_r;
  logic [1:0] gm_r;
  logic [DATA_BITS-1:0] od_r;
  logic [TAG_BITS-1:0] ot_r;
  logic acc, snt;
  logic [7:0] ty;
  logic [1:0] gm;
  logic [DATA_BITS-1:0] od;
  logic [TAG_BITS-1:0] ot;
  logic go, st, rpl, serve;
  logic [SOURCE_BITS-1:0] sr;
  logic [TAG_BITS-1:0] tg;
  logic [DATA_BITS-1:0] dt;
  logic vld, hit, evict, empty, fo, done;

  assign q_ready = !ov_r || out_ready;
  assign go = q_valid && q_ready;

  always_comb begin
    rpl = q_op == l2d_pkg::OP_RPL;
    st = rpl ? (stype_r == l2d_pkg::T_STORE) : q_store;
    sr = rpl ? ssrc_r : q_src;
    tg = rpl ? stag_r : q_tag;
    dt = rpl ? sdata_r : q_data;
    // sender ids past the sharer count select no bit
    sbit = '0;
    for (int i = 0; i < SHARER_COUNT; i++) sbit[i] = int'(q_src) == i;
    if (rpl) begin
      sbit = '0;
      for (int i = 0; i < SHARER_COUNT; i++) sbit[i] = int'(ssrc_r) == i;
    end
    vld = vd_r == l2d_pkg::VD_CLEAN || vd_r == l2d_pkg::VD_DIRTY;
    hit = vld && tg == ltag_r;
    evict = vld && tg != ltag_r;
    empty = vd_r == l2d_pkg::VD_INVAL;
    fo = sr == own_r;
    done = hit && (mesi_r != l2d_pkg::ST_E || fo) && !(st && mesi_r == l2d_pkg::ST_S);
    vd_nxt = vd_r; mesi_nxt = mesi_r; ph_nxt = ph_r; ltag_nxt = ltag_r; stag_nxt = stag_r;
    ldata_nxt = ldata_r; sdata_nxt = sdata_r; own_nxt = own_r; ssrc_nxt = ssrc_r;
    shr_nxt = shr_r; stype_nxt = stype_r;
    acc = 1'b0; snt = 1'b0; ty = '0; gm = '0; od = '0; ot = '0;
    serve = 1'b0;
    case (q_op)
      l2d_pkg::OP_REQ: serve = ph_r == l2d_pkg::PH_FREE;
      l2d_pkg::OP_RPL: serve = ph_r == l2d_pkg::PH_PEND &&
        (stype_r == l2d_pkg::T_LOAD || stype_r == l2d_pkg::T_STORE);
      l2d_pkg::OP_WB: begin
        acc = 1'b1; snt = 1'b1; ty = l2d_pkg::T_NODATA;
        mesi_nxt = l2d_pkg::ST_I; ldata_nxt = q_data; vd_nxt = l2d_pkg::VD_DIRTY;
        if (ph_r == l2d_pkg::PH_WAIT) ph_nxt = l2d_pkg::PH_PEND;
      end
      l2d_pkg::OP_FWDACK: begin
        acc = 1'b1;
        if (ph_r != l2d_pkg::PH_FREE) ph_nxt = l2d_pkg::PH_PEND;
        if (mesi_r == l2d_pkg::ST_E) begin
          mesi_nxt = q_lfwd ? l2d_pkg::ST_S : l2d_pkg::ST_I;
          ldata_nxt = q_data; vd_nxt = l2d_pkg::VD_DIRTY;
        end
        if (q_lfwd) shr_nxt = sbit;
      end
      l2d_pkg::OP_INVACK: begin
        acc = 1'b1;
        shr_nxt = shr_r & ~sbit;
        if (shr_nxt == '0) begin
          if (ph_r != l2d_pkg::PH_FREE) ph_nxt = l2d_pkg::PH_PEND;
          mesi_nxt = l2d_pkg::ST_I;
        end
      end
      l2d_pkg::OP_LMEM: begin
        acc = 1'b1;
        if (ph_r != l2d_pkg::PH_FREE) ph_nxt = l2d_pkg::PH_PEND;
        ldata_nxt = q_data; ltag_nxt = q_tag; vd_nxt = l2d_pkg::VD_CLEAN;
      end
      l2d_pkg::OP_SMEM: begin
        acc = 1'b1;
        if (ph_r != l2d_pkg::PH_FREE) ph_nxt = l2d_pkg::PH_PEND;
      end
      default: acc = 1'b0;
    endcase
    if (serve) begin
      acc = 1'b1; snt = 1'b1;
      if (evict) begin
        if (mesi_r == l2d_pkg::ST_I)
          ty = (vd_r == l2d_pkg::VD_DIRTY) ? l2d_pkg::T_MEM_STORE : l2d_pkg::T_MEM_LOAD;
        else
          ty = (mesi_r == l2d_pkg::ST_S) ? l2d_pkg::T_FWD_INV : l2d_pkg::T_FWD_STORE;
      end else if (empty) ty = l2d_pkg::T_MEM_LOAD;
      else if (mesi_r == l2d_pkg::ST_E)
        ty = fo ? l2d_pkg::T_DATA : (st ? l2d_pkg::T_FWD_STORE : l2d_pkg::T_FWD_LOAD);
      else if (st && mesi_r == l2d_pkg::ST_S) ty = l2d_pkg::T_FWD_INV;
      else ty = l2d_pkg::T_DATA;
      gm = st ? l2d_pkg::ST_M : (mesi_r == l2d_pkg::ST_S ? l2d_pkg::ST_S : l2d_pkg::ST_E);
      od = (st && done) ? dt : ldata_r;
      ot = (vd_r == l2d_pkg::VD_DIRTY) ? ltag_r : tg;
      if (!done && !rpl) begin
        stype_nxt = st ? l2d_pkg::T_STORE : l2d_pkg::T_LOAD;
        stag_nxt = q_tag; ssrc_nxt = q_src;
        if (st) sdata_nxt = q_data;
      end
      ph_nxt = done ? l2d_pkg::PH_FREE : l2d_pkg::PH_WAIT;
      if (done) begin
        if (!st || mesi_r == l2d_pkg::ST_I) own_nxt = sr;
        if (!st && mesi_r == l2d_pkg::ST_S) shr_nxt = shr_r | sbit;
      end
      if (hit && mesi_r == l2d_pkg::ST_I) mesi_nxt = l2d_pkg::ST_E;
      if (evict && mesi_r == l2d_pkg::ST_I) vd_nxt = l2d_pkg::VD_INVAL;
    end
  end

  assign out_valid = ov_r;
  assign out_accepted = acc_r;
  assign out_sent = sent_r;
  assign out_type = ty_r;
  assign out_mesi = gm_r;
  assign out_data = od_r;
  assign out_tag = ot_r;
  assign slot_phase = ph_r;

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= acc; sent_r <= snt; ty_r <= ty; gm_r <= gm; od_r <= od; ot_r <= ot;
    end
    if (!rst_n) begin
      ov_r <= 1'b0;
      vd_r <= '0; mesi_r <= '0; ph_r <= '0; ltag_r <= '0; stag_r <= '0;
      ldata_r <= '0; sdata_r <= '0; own_r <= '0; ssrc_r <= '0; shr_r <= '0;
      stype_r <= '0;
    end else begin
      if (go) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (go) begin
        vd_r <= vd_nxt; mesi_r <= mesi_nxt; ph_r <= ph_nxt; ltag_r <= ltag_nxt;
        stag_r <= stag_nxt; ldata_r <= ldata_nxt; sdata_r <= sdata_nxt;
        own_r <= own_nxt; ssrc_r <= ssrc_nxt; shr_r <= shr_nxt; stype_r <= stype_nxt;
      end
    end
  end
endmodule

[test/tb_l2_mesi_directory_line_controller.sv]
module tb_l2_mesi_directory_line_controller;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        acc;
    logic        snt;
    logic [7:0]  ty;
    logic [1:0]  mesi;
    logic [63:0] data;
    logic [25:0] tag;
  } line_result_t;

  typedef struct {
    logic [1:0]   kind;
    logic [7:0]   ty;
    logic [63:0]  data;
    logic [5:0]   src;
    logic [25:0]  tag;
    bit           typed;
    line_result_t res;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1600;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_kind;
  logic [7:0] in_msg_type;
  logic [63:0] in_msg_data;
  logic [5:0] in_msg_source;
  logic [25:0] in_msg_tag;
  logic out_accepted, out_sent;
  logic [7:0] out_type;
  logic [1:0] out_mesi;
  logic [63:0] out_data;
  logic [25:0] out_tag;

  l2_mesi_directory_line_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_msg_type(in_msg_type), .in_msg_data(in_msg_data),
    .in_msg_source(in_msg_source), .in_msg_tag(in_msg_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_sent(out_sent), .out_type(out_type),
    .out_mesi(out_mesi), .out_data(out_data), .out_tag(out_tag)
  );

  // mirror of the line and the parked request
  logic [1:0]  m_vd, m_mesi, m_phase;
  logic [25:0] m_tag, m_ptag;
  logic [63:0] m_data, m_sharers, m_pdata;
  logic [5:0]  m_owner, m_psrc;
  logic [7:0]  m_ptype;

  line_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  bit sender_done = 0;

  function automatic line_result_t serve_request(bit store, logic [5:0] src,
                                                 logic [25:0] tag, logic [63:0] data,
                                                 bit replay);
    line_result_t r;
    bit valid, hit, evict, empty, from_owner, done;
    logic [1:0] st;
    logic [7:0] ty;
    valid = (m_vd == l2d_pkg::VD_CLEAN) || (m_vd == l2d_pkg::VD_DIRTY);
    hit = valid && tag == m_tag;
    evict = valid && tag != m_tag;
    empty = m_vd == l2d_pkg::VD_INVAL;
    from_owner = src == m_owner;
    st = m_mesi;
    done = hit && (st != l2d_pkg::ST_E || from_owner);
    if (store && st == l2d_pkg::ST_S) done = 0;
    if (evict)
      ty = (st == l2d_pkg::ST_I)
           ? ((m_vd == l2d_pkg::VD_DIRTY) ? l2d_pkg::T_MEM_STORE : l2d_pkg::T_MEM_LOAD)
           : ((st == l2d_pkg::ST_S) ? l2d_pkg::T_FWD_INV : l2d_pkg::T_FWD_STORE);
    else if (empty) ty = l2d_pkg::T_MEM_LOAD;
    else if (st == l2d_pkg::ST_E)
      ty = from_owner ? l2d_pkg::T_DATA : (store ? l2d_pkg::T_FWD_STORE : l2d_pkg::T_FWD_LOAD);
    else if (store && st == l2d_pkg::ST_S) ty = l2d_pkg::T_FWD_INV;
    else ty = l2d_pkg::T_DATA;
    r.acc = 1;
    r.snt = 1;
    r.ty = ty;
    r.mesi = store ? l2d_pkg::ST_M : ((st == l2d_pkg::ST_S) ? l2d_pkg::ST_S : l2d_pkg::ST_E);
    r.data = (store && done) ? data : m_data;
    r.tag = (m_vd == l2d_pkg::VD_DIRTY) ? m_tag : tag;
    if (!done && !replay) begin
      m_ptype = store ? l2d_pkg::T_STORE : l2d_pkg::T_LOAD;
      m_ptag = tag;
      m_psrc = src;
      if (store) m_pdata = data;
    end
    m_phase = done ? l2d_pkg::PH_FREE : l2d_pkg::PH_WAIT;
    if (done) begin
      if (!store || st == l2d_pkg::ST_I) m_owner = src;
      if (!store && st == l2d_pkg::ST_S) m_sharers |= 64'd1 << src;
    end
    if (hit && st == l2d_pkg::ST_I) m_mesi = l2d_pkg::ST_E;
    if (evict && st == l2d_pkg::ST_I) m_vd = l2d_pkg::VD_INVAL;
    return r;
  endfunction

  function automatic line_result_t predict_line(logic [1:0] kind, logic [7:0] ty,
                                                logic [63:0] data, logic [5:0] src,
                                                logic [25:0] tag);
    line_result_t r;
    r = '0;
    if (kind == l2d_pkg::K_REQ) begin
      if (m_phase == l2d_pkg::PH_FREE && (ty == l2d_pkg::T_LOAD || ty == l2d_pkg::T_STORE))
        r = serve_request(ty == l2d_pkg::T_STORE, src, tag, data, 0);
    end else if (kind == l2d_pkg::K_RPL) begin
      if (m_phase == l2d_pkg::PH_PEND &&
          (m_ptype == l2d_pkg::T_LOAD || m_ptype == l2d_pkg::T_STORE))
        r = serve_request(m_ptype == l2d_pkg::T_STORE, m_psrc, m_ptag, m_pdata, 1);
    end else if (kind == l2d_pkg::K_RSP) begin
      r.acc = 1;
      if (ty == l2d_pkg::T_WB) begin
        m_mesi = l2d_pkg::ST_I;
        m_data = data;
        m_vd = l2d_pkg::VD_DIRTY;
        if (m_phase == l2d_pkg::PH_WAIT) m_phase = l2d_pkg::PH_PEND;
        r.snt = 1;
        r.ty = l2d_pkg::T_NODATA;
      end else if (ty == l2d_pkg::T_ACK_LFWD || ty == l2d_pkg::T_ACK_SFWD) begin
        if (m_phase != l2d_pkg::PH_FREE) m_phase = l2d_pkg::PH_PEND;
        if (m_mesi == l2d_pkg::ST_E) begin
          m_mesi = (ty == l2d_pkg::T_ACK_LFWD) ? l2d_pkg::ST_S : l2d_pkg::ST_I;
          m_data = data;
          m_vd = l2d_pkg::VD_DIRTY;
        end
        if (ty == l2d_pkg::T_ACK_LFWD) m_sharers = 64'd1 << src;
      end else if (ty == l2d_pkg::T_ACK_INV) begin
        m_sharers &= ~(64'd1 << src);
        if (m_sharers == 0) begin
          if (m_phase != l2d_pkg::PH_FREE) m_phase = l2d_pkg::PH_PEND;
          m_mesi = l2d_pkg::ST_I;
        end
      end else if (ty == l2d_pkg::T_ACK_LMEM) begin
        if (m_phase != l2d_pkg::PH_FREE) m_phase = l2d_pkg::PH_PEND;
        m_data = data;
        m_tag = tag;
        m_vd = l2d_pkg::VD_CLEAN;
      end else if (ty == l2d_pkg::T_ACK_SMEM) begin
        if (m_phase != l2d_pkg::PH_FREE) m_phase = l2d_pkg::PH_PEND;
      end else begin
        r.acc = 0;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  bit sender_calm = 0;

  task automatic drive_item(logic [1:0] kind, logic [7:0] ty, logic [63:0] data,
                            logic [5:0] src, logic [25:0] tag, bit typed,
                            line_result_t typed_res);
    int gap;
    line_result_t r;
    gap = sender_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_msg_type <= ty;
    in_msg_data <= data;
    in_msg_source <= src;
    in_msg_tag <= tag;
    do @(posedge clk); while (!in_ready);
    r = predict_line(kind, ty, data, src, tag);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  function automatic logic [5:0] pick_source();
    return ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
  endfunction

  function automatic logic [25:0] pick_tag();
    return ($urandom_range(0, 5) == 0) ? 26'($urandom) : 26'($urandom_range(1, 3));
  endfunction

  dir_row_t dir_table[$];

  task automatic add_row(logic [1:0] kind, logic [7:0] ty, logic [63:0] data,
                         logic [5:0] src, logic [25:0] tag, bit typed = 0,
                         line_result_t res = '0);
    dir_row_t row;
    row.kind = kind; row.ty = ty; row.data = data; row.src = src; row.tag = tag;
    row.typed = typed; row.res = res;
    dir_table.push_back(row);
  endtask

  initial begin
    line_result_t ignored, ack_only;
    logic [1:0] kind;
    logic [7:0] ty;
    int pick;
    ignored = '0;
    ack_only = '0;
    ack_only.acc = 1;
    m_vd = '0; m_mesi = '0; m_phase = '0; m_tag = '0; m_ptag = '0; m_data = '0;
    m_sharers = '0; m_pdata = '0; m_owner = '0; m_psrc = '0; m_ptype = '0;
    rst_n <= 0;
    in_valid <= 0;
    in_kind <= l2d_pkg::K_REQ;
    in_msg_type <= '0;
    in_msg_data <= '0;
    in_msg_source <= '0;
    in_msg_tag <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty line: load goes to memory with an exclusive grant
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_LOAD, 64'h0, 6'd3, 26'd5, 1,
            '{1'b1, 1'b1, l2d_pkg::T_MEM_LOAD, l2d_pkg::ST_E, 64'h0, 26'd5});
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_STORE, '1, 6'd3, 26'd5, 1, ignored);   // slot busy
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0, 1, ignored);   // waiting, not pending
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_LMEM, 64'hA5A5_5A5A_F00D_0001, 6'd0, 26'd5, 1,
            ack_only);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0, 1, ignored);   // nothing pending
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_LOAD, 64'h0, 6'd63, 26'd5);  // exclusive, other owner
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_LFWD, '1, 6'd63, 26'd0, 1, ack_only);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_STORE, '1, 6'd1, 26'd5);      // store on shared line
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_INV, 64'h0, 6'd3, 26'd0);
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_INV, 64'h0, 6'd63, 26'd0);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_WB, '1, 6'd2, 26'd0, 1,
            '{1'b1, 1'b1, l2d_pkg::T_NODATA, 2'd0, 64'h0, 26'd0});
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_LOAD, 64'h0, 6'd0, '1);       // dirty victim evicted
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_SMEM, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_LMEM, 64'h0, 6'd0, '1);
    add_row(l2d_pkg::K_RPL, 8'h0, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_REQ, l2d_pkg::T_STORE, 64'h1234, 6'd0, '1);
    add_row(l2d_pkg::K_RSP, l2d_pkg::T_ACK_SFWD, 64'h0, 6'd0, 26'd0);
    add_row(l2d_pkg::K_RSP, 8'hFF, '1, '1, '1, 1, ignored);          // unknown response type
    add_row(2'd3, l2d_pkg::T_LOAD, '1, '1, '1, 1, ignored);          // undefined kind
    add_row(l2d_pkg::K_REQ, 8'hFF, '1, '1, '1, 1, ignored);          // unknown request type

    foreach (dir_table[i])
      drive_item(dir_table[i].kind, dir_table[i].ty, dir_table[i].data, dir_table[i].src,
                 dir_table[i].tag, dir_table[i].typed, dir_table[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        kind = l2d_pkg::K_REQ;
        ty = $urandom_range(0, 1) ? l2d_pkg::T_LOAD : l2d_pkg::T_STORE;
      end else if (pick < 75) begin
        kind = l2d_pkg::K_RSP;
        case ($urandom_range(0, 5))
          0: ty = l2d_pkg::T_WB;
          1: ty = l2d_pkg::T_ACK_LFWD;
          2: ty = l2d_pkg::T_ACK_SFWD;
          3: ty = l2d_pkg::T_ACK_INV;
          4: ty = l2d_pkg::T_ACK_LMEM;
          default: ty = l2d_pkg::T_ACK_SMEM;
        endcase
      end else if (pick < 93) begin
        kind = l2d_pkg::K_RPL;
        ty = 8'($urandom);
      end else begin
        kind = 2'($urandom);
        ty = 8'($urandom);
      end
      drive_item(kind, ty, {$urandom, $urandom}, pick_source(), pick_tag(), 0, ignored);
    end
    in_valid <= 0;
    sender_done = 1;
  end

  // result side: random stalls, some stall-free results, and one long hold to back up the block
  initial begin
    int stall;
    bit held = 0;
    out_ready <= 0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (!held && results_seen >= 300) begin
        held = 1;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected item", 64'h0, 64'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_accepted !== want.acc)
          report("accepted", 64'(out_accepted), 64'(want.acc));
        if (out_sent !== want.snt) report("sent", 64'(out_sent), 64'(want.snt));
        if (out_type !== want.ty) report("type", 64'(out_type), 64'(want.ty));
        if (out_mesi !== want.mesi) report("mesi", 64'(out_mesi), 64'(want.mesi));
        if (out_data !== want.data) report("data", out_data, want.data);
        if (out_tag !== want.tag) report("tag", 64'(out_tag), 64'(want.tag));
      end
      results_seen++;
    end
  end

  initial begin
    int cycles = 0;
    while (!(sender_done && expected_results.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
    end else begin
      repeat (20) @(posedge clk);
      if (errors == 0 && expected_results.size() == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

[l2_mesi_directory_line_controller.f]
+incdir+sv
sv/l2d_pkg.sv
sv/l2d_front.sv
sv/l2d_back.sv
sv/l2_mesi_directory_line_controller.sv
test/tb_l2_mesi_directory_line_controller.sv
